[rtl/zcdp_pkg.sv]
// ----------------------------------------------------------------------------
// zcdp_pkg
// shared constants for the zip central directory parser: signature bytes,
// fixed header layout and result status codes
// ----------------------------------------------------------------------------
package zcdp_pkg;

  // fixed header of one central directory record
  localparam int unsigned HdrLen  = 46;
  localparam int unsigned PosW    = 6;
  localparam int unsigned SkipW   = 18;
  localparam int unsigned CountW  = 16;

  // record signature, byte order as seen on the stream
  localparam logic [7:0] Sig0 = 8'h50;
  localparam logic [7:0] Sig1 = 8'h4b;
  localparam logic [7:0] Sig2 = 8'h01;
  localparam logic [7:0] Sig3 = 8'h02;

  // byte offsets inside the fixed header
  localparam logic [PosW-1:0] PosMethod  = 6'd10;
  localparam logic [PosW-1:0] PosCrc     = 6'd16;
  localparam logic [PosW-1:0] PosCsize   = 6'd20;
  localparam logic [PosW-1:0] PosUsize   = 6'd24;
  localparam logic [PosW-1:0] PosName    = 6'd28;
  localparam logic [PosW-1:0] PosExtra   = 6'd30;
  localparam logic [PosW-1:0] PosComment = 6'd32;
  localparam logic [PosW-1:0] PosLocal   = 6'd42;
  localparam logic [PosW-1:0] PosLast    = 6'(HdrLen - 1);

  // result status codes
  localparam logic [1:0] StatRecord    = 2'd0;
  localparam logic [1:0] StatCleanEnd  = 2'd1;
  localparam logic [1:0] StatBadSig    = 2'd2;
  localparam logic [1:0] StatTruncated = 2'd3;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = Sig0;
      2'd1:    b = Sig1;
      2'd2:    b = Sig2;
      default: b = Sig3;
    endcase
    return b;
  endfunction

endpackage

[rtl/zip_central_directory_parser.sv]
// ----------------------------------------------------------------------------
// zip_central_directory_parser
// walks a zip central directory byte by byte, reports one result per record
// header plus end, truncation and bad signature results
// ----------------------------------------------------------------------------
// The parser takes one directory byte per transfer and sustains one byte per
// clock: each byte only updates the header position, the skip counter and one
// byte lane of the field registers, and any result it causes is written to
// the output register in the same cycle. So a result appears on the output in
// the cycle after the byte that caused it is taken. The output register parts
// the two sides: a new byte is taken whenever the output register is empty or
// its result is being taken in the same cycle, so the input stalls only while
// a finished result waits. A record result comes with the 46th header byte;
// name, extra and comment bytes are counted off without results unless final.
// After a bad signature every byte is dropped until the final byte, and any
// final byte returns the parser to its reset state for the next directory.
module zip_central_directory_parser
  import zcdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // byte channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        final_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic        is_end,
  output logic [15:0] entry_index,
  output logic [15:0] method,
  output logic [31:0] crc_value,
  output logic [31:0] compressed_size,
  output logic [31:0] uncompressed_size,
  output logic [31:0] local_offset,
  output logic [15:0] name_length,
  output logic [15:0] extra_length,
  output logic [15:0] comment_length
);

  // parser state
  logic [PosW-1:0]   header_position;
  logic [SkipW-1:0]  skip_remaining;
  logic [CountW-1:0] record_count;
  logic              stopped_flag;

  // field assembly, every lane is rewritten in each header
  // the top byte of the local offset comes straight from the last header byte
  logic [15:0] fa_method;
  logic [31:0] fa_crc;
  logic [31:0] fa_csize;
  logic [31:0] fa_usize;
  logic [23:0] fa_local;
  logic [15:0] fa_name;
  logic [15:0] fa_extra;
  logic [15:0] fa_comment;

  logic in_xfer;
  logic out_xfer;

  // decoded per-byte actions
  logic sig_bad;
  logic in_header;
  logic hdr_done;
  logic emit;
  logic [1:0] emit_status;
  logic emit_end;
  logic clear_all;

  logic [PosW-1:0]   header_position_next;
  logic [SkipW-1:0]  skip_remaining_next;
  logic [CountW-1:0] record_count_next;
  logic              stopped_flag_next;
  logic [SkipW-1:0]  skip_sum;

  // the output register frees up when empty or drained this cycle
  assign in_stall = out_valid && out_stall;
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // header bytes are taken only when neither stopped nor skipping
  assign in_header = !stopped_flag && (skip_remaining == '0);
  assign sig_bad   = in_header && (header_position < PosW'(4))
                     && (data_byte != sig_byte(header_position[1:0]));
  assign hdr_done  = in_header && !sig_bad && (header_position == PosLast);

  assign skip_sum = SkipW'(fa_name) + SkipW'(fa_extra) + SkipW'(fa_comment);

  always_comb begin
    emit        = 1'b0;
    emit_status = StatRecord;
    emit_end    = 1'b1;
    clear_all   = final_byte;
    header_position_next = header_position;
    skip_remaining_next  = skip_remaining;
    record_count_next    = record_count;
    stopped_flag_next    = stopped_flag;
    if (stopped_flag) begin
      // dropped bytes, a final byte only re-arms the parser
    end else if (skip_remaining != '0) begin
      skip_remaining_next = skip_remaining - SkipW'(1);
      if (final_byte) begin
        emit        = 1'b1;
        emit_status = StatCleanEnd;
      end
    end else if (sig_bad) begin
      emit              = 1'b1;
      emit_status       = StatBadSig;
      stopped_flag_next = 1'b1;
    end else if (hdr_done) begin
      emit                 = 1'b1;
      emit_status          = StatRecord;
      emit_end             = final_byte;
      record_count_next    = record_count + CountW'(1);
      skip_remaining_next  = skip_sum;
      header_position_next = '0;
    end else begin
      header_position_next = header_position + PosW'(1);
      if (final_byte) begin
        emit        = 1'b1;
        emit_status = StatTruncated;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      header_position <= '0;
      skip_remaining  <= '0;
      record_count    <= '0;
      stopped_flag    <= 1'b0;
    end else if (in_xfer) begin
      if (clear_all) begin
        header_position <= '0;
        skip_remaining  <= '0;
        record_count    <= '0;
        stopped_flag    <= 1'b0;
      end else begin
        header_position <= header_position_next;
        skip_remaining  <= skip_remaining_next;
        record_count    <= record_count_next;
        stopped_flag    <= stopped_flag_next;
      end
    end
  end

  // byte lanes of the little-endian header fields
  always_ff @(posedge clk) begin
    if (in_xfer && in_header) begin
      case (header_position)
        PosMethod:          fa_method[7:0]   <= data_byte;
        PosMethod + 6'd1:   fa_method[15:8]  <= data_byte;
        PosCrc:             fa_crc[7:0]      <= data_byte;
        PosCrc + 6'd1:      fa_crc[15:8]     <= data_byte;
        PosCrc + 6'd2:      fa_crc[23:16]    <= data_byte;
        PosCrc + 6'd3:      fa_crc[31:24]    <= data_byte;
        PosCsize:           fa_csize[7:0]    <= data_byte;
        PosCsize + 6'd1:    fa_csize[15:8]   <= data_byte;
        PosCsize + 6'd2:    fa_csize[23:16]  <= data_byte;
        PosCsize + 6'd3:    fa_csize[31:24]  <= data_byte;
        PosUsize:           fa_usize[7:0]    <= data_byte;
        PosUsize + 6'd1:    fa_usize[15:8]   <= data_byte;
        PosUsize + 6'd2:    fa_usize[23:16]  <= data_byte;
        PosUsize + 6'd3:    fa_usize[31:24]  <= data_byte;
        PosName:            fa_name[7:0]     <= data_byte;
        PosName + 6'd1:     fa_name[15:8]    <= data_byte;
        PosExtra:           fa_extra[7:0]    <= data_byte;
        PosExtra + 6'd1:    fa_extra[15:8]   <= data_byte;
        PosComment:         fa_comment[7:0]  <= data_byte;
        PosComment + 6'd1:  fa_comment[15:8] <= data_byte;
        PosLocal:           fa_local[7:0]    <= data_byte;
        PosLocal + 6'd1:    fa_local[15:8]   <= data_byte;
        PosLocal + 6'd2:    fa_local[23:16]  <= data_byte;
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_xfer && emit) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && emit) begin
      status      <= emit_status;
      is_end      <= emit_end;
      entry_index <= record_count;
      if (hdr_done) begin
        // last header byte is the top byte of the local offset
        method            <= fa_method;
        crc_value         <= fa_crc;
        compressed_size   <= fa_csize;
        uncompressed_size <= fa_usize;
        local_offset      <= {data_byte, fa_local[23:0]};
        name_length       <= fa_name;
        extra_length      <= fa_extra;
        comment_length    <= fa_comment;
      end else begin
        method            <= '0;
        crc_value         <= '0;
        compressed_size   <= '0;
        uncompressed_size <= '0;
        local_offset      <= '0;
        name_length       <= '0;
        extra_length      <= '0;
        comment_length    <= '0;
      end
    end
  end

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    header_position <= PosLast)
    else $error("header position past the fixed header");

  a_skip_at_boundary: assert property (@(posedge clk) disable iff (rst)
    (skip_remaining != '0) |-> (header_position == '0) && !stopped_flag)
    else $error("skipping while inside a header or stopped");

  a_final_rearms: assert property (@(posedge clk) disable iff (rst)
    (in_xfer && final_byte) |=> (header_position == '0) && (skip_remaining == '0)
      && (record_count == '0) && !stopped_flag)
    else $error("final byte did not return the parser to reset state");

  a_nonrecord_ends: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != StatRecord)) |-> is_end)
    else $error("non-record result without end mark");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid && $stable(status) && $stable(entry_index))
    else $error("waiting result lost or changed");

endmodule

[bench/zip_central_directory_parser_tb.sv]
// ----------------------------------------------------------------------------
// zip_central_directory_parser_tb
// self-checking bench for the central directory parser: directed directories
// for the field extremes, record on the final byte, bad signatures and
// truncation, then random directories built mostly from well-formed records;
// a byte-level model predicts every result and a monitor compares them
// ----------------------------------------------------------------------------
module zip_central_directory_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import zcdp_pkg::*;

  // signature as one word, byte 0 in the low lane
  localparam logic [31:0] SigWord = {Sig3, Sig2, Sig1, Sig0};

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        final_byte;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  status;
  logic        is_end;
  logic [15:0] entry_index;
  logic [15:0] method;
  logic [31:0] crc_value;
  logic [31:0] compressed_size;
  logic [31:0] uncompressed_size;
  logic [31:0] local_offset;
  logic [15:0] name_length;
  logic [15:0] extra_length;
  logic [15:0] comment_length;

  // one result as the parser reports it
  typedef struct packed {
    logic [1:0]  status;
    logic        is_end;
    logic [15:0] entry_index;
    logic [15:0] method;
    logic [31:0] crc_value;
    logic [31:0] compressed_size;
    logic [31:0] uncompressed_size;
    logic [31:0] local_offset;
    logic [15:0] name_length;
    logic [15:0] extra_length;
    logic [15:0] comment_length;
  } dir_entry_t;

  zip_central_directory_parser dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .data_byte         (data_byte),
    .final_byte        (final_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .status            (status),
    .is_end            (is_end),
    .entry_index       (entry_index),
    .method            (method),
    .crc_value         (crc_value),
    .compressed_size   (compressed_size),
    .uncompressed_size (uncompressed_size),
    .local_offset      (local_offset),
    .name_length       (name_length),
    .extra_length      (extra_length),
    .comment_length    (comment_length)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // parser model: walks the same byte stream as the block
  // ---------------------------------------------------------------------------
  logic [5:0]  hdr_pos;
  logic [17:0] skip_left;
  logic [15:0] entries_seen;
  bit          halted;
  logic [15:0] f_method, f_name, f_extra, f_comment;
  logic [31:0] f_crc, f_csize, f_usize, f_local;

  dir_entry_t  pending_entries [$];
  int          entries_predicted = 0;
  int          live_bytes = 0;
  int          mismatches = 0;
  int          quiet_left [2] = '{0, 0};
  logic [7:0]  dir_bytes [$];

  function automatic void clear_fields();
    {f_method, f_crc, f_csize, f_usize, f_local, f_name, f_extra, f_comment} = '0;
  endfunction

  // back to the state of a fresh directory
  function automatic void clear_parser();
    hdr_pos      = '0;
    skip_left    = '0;
    entries_seen = '0;
    halted       = 1'b0;
    clear_fields();
  endfunction

  // advance the model by one byte, returns 1 when the byte causes a result
  function automatic bit walk_byte(input logic [7:0] b, input bit fin,
                                   output dir_entry_t res);
    res             = '0;
    res.entry_index = entries_seen;
    res.is_end      = fin;
    // everything after a bad signature is dropped up to the final byte
    if (halted) begin
      if (fin) clear_parser();
      return 1'b0;
    end
    // name, extra and comment bytes: a final byte here is still a clean end
    if (skip_left != '0) begin
      skip_left = skip_left - 1'b1;
      if (fin) begin
        res.status = StatCleanEnd;
        clear_parser();
        return 1'b1;
      end
      return 1'b0;
    end
    if (hdr_pos == '0) clear_fields();
    // signature check, a stop result always closes the directory
    if (hdr_pos < 6'd4 && b != SigWord[8*hdr_pos[1:0] +: 8]) begin
      res.status = StatBadSig;
      res.is_end = 1'b1;
      if (fin) clear_parser();
      else halted = 1'b1;
      return 1'b1;
    end
    // little-endian field lanes
    if (hdr_pos >= PosMethod && hdr_pos < PosMethod + 2)
      f_method[8*int'(hdr_pos - PosMethod) +: 8] = b;
    else if (hdr_pos >= PosCrc && hdr_pos < PosCrc + 4)
      f_crc[8*int'(hdr_pos - PosCrc) +: 8] = b;
    else if (hdr_pos >= PosCsize && hdr_pos < PosCsize + 4)
      f_csize[8*int'(hdr_pos - PosCsize) +: 8] = b;
    else if (hdr_pos >= PosUsize && hdr_pos < PosUsize + 4)
      f_usize[8*int'(hdr_pos - PosUsize) +: 8] = b;
    else if (hdr_pos >= PosName && hdr_pos < PosName + 2)
      f_name[8*int'(hdr_pos - PosName) +: 8] = b;
    else if (hdr_pos >= PosExtra && hdr_pos < PosExtra + 2)
      f_extra[8*int'(hdr_pos - PosExtra) +: 8] = b;
    else if (hdr_pos >= PosComment && hdr_pos < PosComment + 2)
      f_comment[8*int'(hdr_pos - PosComment) +: 8] = b;
    else if (hdr_pos >= PosLocal && hdr_pos < PosLocal + 4)
      f_local[8*int'(hdr_pos - PosLocal) +: 8] = b;
    hdr_pos = hdr_pos + 1'b1;
    // fixed header complete: record result, then count off the variable part
    if (hdr_pos == 6'(HdrLen)) begin
      res.status            = StatRecord;
      res.method            = f_method;
      res.crc_value         = f_crc;
      res.compressed_size   = f_csize;
      res.uncompressed_size = f_usize;
      res.local_offset      = f_local;
      res.name_length       = f_name;
      res.extra_length      = f_extra;
      res.comment_length    = f_comment;
      entries_seen          = entries_seen + 1'b1;
      skip_left             = 18'(f_name) + 18'(f_extra) + 18'(f_comment);
      hdr_pos               = '0;
      if (fin) clear_parser();
      return 1'b1;
    end
    if (fin) begin
      res.status = StatTruncated;
      clear_parser();
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // ---------------------------------------------------------------------------
  // idle gaps: mostly none or short, a few long, now and then a quiet stretch
  // side 0 is the byte sender, side 1 the result stall
  // ---------------------------------------------------------------------------
  function automatic int pick_gap(input int side);
    int roll;
    if (quiet_left[side] > 0) begin
      quiet_left[side]--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 2) begin
      quiet_left[side] = $urandom_range(30, 120);
      return 0;
    end
    if (roll < 55) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // result side stall pattern, changes only at the falling edge
  initial begin
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = pick_gap(1);
      if (hold > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      out_stall <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------------------
  // byte sender: one transfer, predicted when it is taken
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b, input bit fin);
    int         gap;
    dir_entry_t res;
    gap = pick_gap(0);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid   <= 1'b1;
    data_byte  <= b;
    final_byte <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // bytes dropped after a stop do not count as live stimulus
    if (!halted) live_bytes++;
    if (walk_byte(b, fin, res)) begin
      pending_entries.push_back(res);
      entries_predicted++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // directory builder
  // ---------------------------------------------------------------------------
  // one 46-byte fixed header, bad_pos 0..3 corrupts that signature byte
  function automatic void add_record(input int bad_pos, input logic [15:0] meth,
                                     input logic [31:0] crc, csize, usize, loc,
                                     input logic [15:0] nlen, elen, clen);
    logic [7:0] hdr [HdrLen];
    for (int i = 0; i < HdrLen; i++) hdr[i] = 8'($urandom);
    for (int i = 0; i < 4; i++) hdr[i] = SigWord[8*i +: 8];
    if (bad_pos < 4) hdr[bad_pos] ^= 8'($urandom_range(1, 255));
    {hdr[PosMethod+1], hdr[PosMethod]} = meth;
    {hdr[PosCrc+3], hdr[PosCrc+2], hdr[PosCrc+1], hdr[PosCrc]} = crc;
    {hdr[PosCsize+3], hdr[PosCsize+2], hdr[PosCsize+1], hdr[PosCsize]} = csize;
    {hdr[PosUsize+3], hdr[PosUsize+2], hdr[PosUsize+1], hdr[PosUsize]} = usize;
    {hdr[PosLocal+3], hdr[PosLocal+2], hdr[PosLocal+1], hdr[PosLocal]} = loc;
    {hdr[PosName+1], hdr[PosName]} = nlen;
    {hdr[PosExtra+1], hdr[PosExtra]} = elen;
    {hdr[PosComment+1], hdr[PosComment]} = clen;
    for (int i = 0; i < HdrLen; i++) dir_bytes.push_back(hdr[i]);
  endfunction

  function automatic void add_filler(input int n);
    for (int i = 0; i < n; i++) dir_bytes.push_back(8'($urandom));
  endfunction

  // send the first upto bytes of the built directory, the last one final
  task automatic send_dir(input int upto);
    for (int i = 0; i < upto; i++) send_byte(dir_bytes[i], i == upto - 1);
    dir_bytes.delete();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  // all-zero and all-ones headers, record on the final byte, end inside skip
  task automatic test_record_bounds();
    add_record(4, '0, '0, '0, '0, '0, '0, '0, '0);
    send_dir(dir_bytes.size());
    // zero lengths: next header follows at once
    add_record(4, '0, '0, '0, '0, '0, '0, '0, '0);
    add_record(4, '1, '1, '1, '1, '1, '1, '1, '1);
    // final on the first of many skip bytes still ends clean
    dir_bytes.push_back(8'hff);
    send_dir(dir_bytes.size());
    // final on the very last skip byte
    add_record(4, 16'd8, 32'h1234_5678, 32'd10, 32'd20, 32'd0, 16'd0, 16'd0, 16'd2);
    add_filler(2);
    send_dir(dir_bytes.size());
  endtask

  task automatic test_bad_signature();
    // stop at the last signature byte, the bytes after it are dropped up to the final byte
    add_record(3, '0, '0, '0, '0, '0, '0, '0, '0);
    add_record(4, '0, '0, '0, '0, '0, '0, '0, '0);
    send_dir(10);
    // bad signature after one record, on the final byte
    add_record(4, '0, '0, '0, '0, '0, '0, '0, '0);
    dir_bytes.push_back(8'h00);
    send_dir(dir_bytes.size());
    // bad first byte, final while stopped gives nothing
    add_record(0, '0, '0, '0, '0, '0, '0, '0, '0);
    send_dir(3);
    add_record(1, '0, '0, '0, '0, '0, '0, '0, '0);
    send_dir(2);
    add_record(2, '0, '0, '0, '0, '0, '0, '0, '0);
    send_dir(5);
  endtask

  task automatic test_truncation();
    add_record(4, '0, '0, '0, '0, '0, '0, '0, '0);
    send_dir(1);
    add_record(4, '0, '0, '0, '0, '0, '0, '0, '0);
    send_dir(4);
    add_record(4, '1, '1, '1, '1, '1, '1, '1, '1);
    send_dir(HdrLen - 1);
  endtask

  // random directories: mostly good records with random fields, some bad
  // signatures, odd cuts and headers with huge lengths ended inside the skip
  task automatic random_dir();
    int          nrec;
    int          bad_pos;
    int          upto;
    bit          huge;
    logic [15:0] nlen, elen, clen, meth;
    nrec = $urandom_range(0, 3);
    if (nrec == 0) add_filler($urandom_range(1, 4));
    for (int r = 0; r < nrec; r++) begin
      bad_pos = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 3) : 4;
      huge    = ($urandom_range(0, 24) == 0);
      if (huge) begin
        nlen = 16'($urandom);
        elen = 16'($urandom);
        clen = 16'($urandom);
      end else if ($urandom_range(0, 5) == 0) begin
        nlen = 16'($urandom_range(0, 20));
        elen = 16'($urandom_range(0, 20));
        clen = 16'($urandom_range(0, 20));
      end else begin
        nlen = 16'($urandom_range(0, 3));
        elen = 16'($urandom_range(0, 3));
        clen = 16'($urandom_range(0, 3));
      end
      case ($urandom_range(0, 2))
        0:       meth = 16'd0;
        1:       meth = 16'd8;
        default: meth = 16'($urandom);
      endcase
      add_record(bad_pos, meth, $urandom, $urandom, $urandom, $urandom, nlen, elen, clen);
      if (huge) begin
        add_filler($urandom_range(1, 3));
        break;
      end
      add_filler(int'(nlen) + int'(elen) + int'(clen));
    end
    if ($urandom_range(0, 99) < 65) upto = dir_bytes.size();
    else upto = $urandom_range(1, dir_bytes.size());
    send_dir(upto);
  endtask

  // random directories until the whole run has sent about 750 live bytes
  task automatic test_random_directories();
    while (live_bytes < 750)
      random_dir();
  endtask

  // ---------------------------------------------------------------------------
  // result monitor
  // ---------------------------------------------------------------------------
  function automatic void compare_field(input string name, input logic [31:0] want, got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : check_results
    dir_entry_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_entries.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %h entry_index %h",
                 $time, status, entry_index);
        mismatches++;
      end else begin
        want = pending_entries.pop_front();
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("is_end", 32'(want.is_end), 32'(is_end));
        compare_field("entry_index", 32'(want.entry_index), 32'(entry_index));
        compare_field("method", 32'(want.method), 32'(method));
        compare_field("crc_value", want.crc_value, crc_value);
        compare_field("compressed_size", want.compressed_size, compressed_size);
        compare_field("uncompressed_size", want.uncompressed_size, uncompressed_size);
        compare_field("local_offset", want.local_offset, local_offset);
        compare_field("name_length", 32'(want.name_length), 32'(name_length));
        compare_field("extra_length", 32'(want.extra_length), 32'(extra_length));
        compare_field("comment_length", 32'(want.comment_length), 32'(comment_length));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // run
  // ---------------------------------------------------------------------------
  initial begin
    rst        = 1'b1;
    in_valid   = 1'b0;
    data_byte  = '0;
    final_byte = 1'b0;
    clear_parser();
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    test_record_bounds();
    test_bad_signature();
    test_truncation();
    test_random_directories();

    @(negedge clk);
    in_valid <= 1'b0;
    // drain, then wait for any stray result
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("zip_central_directory_parser_tb: done, clean");
    end else begin
      $display("zip_central_directory_parser_tb: done, errors");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("zip_central_directory_parser_tb: done, errors");
    $finish;
  end

endmodule
